>>> rtl/core/vbsf_pkg.sv
package vbsf_pkg;

    // Largest volume the ring is sized for.
    localparam int MAX_ROW    = 64;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_HALF   = 2;

    // The ring holds the planes that one window can span.
    localparam int RING_A     = (2 * MAX_HALF + 1) * MAX_ROW * MAX_ROWS;
    localparam int RING_B     = 2 * (MAX_HALF * MAX_ROWS * MAX_ROW + MAX_HALF * MAX_ROW
                                + MAX_HALF) + 1;
    localparam int RING_DEPTH = (RING_A > RING_B) ? RING_A : RING_B;
    localparam int AW         = $clog2(RING_DEPTH);

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_Y_SIZE     = 2'd0;
    localparam logic [1:0] CFG_X_SIZE     = 2'd1;
    localparam logic [1:0] CFG_Z_SIZE     = 2'd2;
    localparam logic [1:0] CFG_HALF_WIDTH = 2'd3;

    // One input beat as it travels from the front to the back.
    typedef struct packed {
        logic [15:0] voxel;
        logic        valid_req;
    } t_item;

endpackage

>>> rtl/core/vbsf_front.sv
module vbsf_front
    import vbsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  [15:0] i_voxel,
    input  logic  i_valid_req,
    output t_item o_item,
    output logic  o_item_valid,
    input  logic  i_item_pop
);

    // Two-entry queue between the input channel and the back end.
    t_item      r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_buf[r_rp];

    // Store accepted beats.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp].voxel     <= i_voxel;
            r_buf[r_wp].valid_req <= i_valid_req;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !i_item_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_item_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> rtl/core/vbsf_back.sv
module vbsf_back
    import vbsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_filtered,
    output logic        o_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_LAST  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [15:0] RING_D = 16'(RING_DEPTH);

    // Modular add on ring addresses; b is below the ring depth.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [15:0] s;
        s = 16'(a) + 16'(b);
        if (s >= RING_D) begin
            s = s - RING_D;
        end
        return AW'(s);
    endfunction

    // Configuration registers.
    logic [6:0]  r_y_size;
    logic [6:0]  r_x_size;
    logic [15:0] r_z_size;
    logic [1:0]  r_half;

    // Scan positions and their ring addresses.
    logic [5:0]    r_wy, r_wx, r_oy, r_ox;
    logic [15:0]   r_wz, r_oz;
    logic [AW-1:0] r_waddr, r_oaddr;

    // Window walk.
    logic [2:0]    r_state;
    logic [15:0]   r_z0, r_z1, r_cz;
    logic [5:0]    r_x0, r_x1, r_y0, r_y1, r_cx, r_cy;
    logic [1:0]    r_dz, r_dx, r_dy;
    logic [AW-1:0] r_addr, r_row, r_pln;
    logic          r_pend;
    logic [22:0]   r_acc;

    // Output register.
    logic          r_o_valid;
    logic [15:0]   r_o_sum;
    logic          r_o_last;

    // Ring memory.
    logic [15:0]   r_mem [RING_DEPTH];
    logic [15:0]   r_rdata;
    logic          w_mem_we;

    // Effective sizes after clamping.
    logic [6:0]  w_ny, w_nx;
    logic [15:0] w_nz;
    logic [1:0]  w_h;
    logic [5:0]  w_ny_m1, w_nx_m1;
    logic [15:0] w_nz_m1;
    logic [12:0] w_plane;

    assign w_ny    = (r_y_size == 7'd0) ? 7'd1 :
                     (r_y_size > 7'(MAX_ROW)) ? 7'(MAX_ROW) : r_y_size;
    assign w_nx    = (r_x_size == 7'd0) ? 7'd1 :
                     (r_x_size > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : r_x_size;
    assign w_nz    = (r_z_size == 16'd0) ? 16'd1 : r_z_size;
    assign w_h     = (r_half > 2'(MAX_HALF)) ? 2'(MAX_HALF) : r_half;
    assign w_ny_m1 = 6'(w_ny - 7'd1);
    assign w_nx_m1 = 6'(w_nx - 7'd1);
    assign w_nz_m1 = w_nz - 16'd1;
    assign w_plane = 13'(14'(w_nx) * 14'(w_ny));

    // Window bounds of the next output voxel.
    logic [16:0] w_zh;
    logic [6:0]  w_xh, w_yh;
    logic [15:0] w_z0, w_z1;
    logic [5:0]  w_x0, w_x1, w_y0, w_y1;
    logic        w_in_vol, w_ready, w_fin;

    assign w_zh = 17'(r_oz) + 17'(w_h);
    assign w_xh = 7'(r_ox) + 7'(w_h);
    assign w_yh = 7'(r_oy) + 7'(w_h);
    assign w_z0 = (r_oz > 16'(w_h)) ? r_oz - 16'(w_h) : 16'd0;
    assign w_x0 = (r_ox > 6'(w_h)) ? r_ox - 6'(w_h) : 6'd0;
    assign w_y0 = (r_oy > 6'(w_h)) ? r_oy - 6'(w_h) : 6'd0;
    assign w_z1 = (w_zh > 17'(w_nz_m1)) ? w_nz_m1 : w_zh[15:0];
    assign w_x1 = (w_xh > 7'(w_nx_m1)) ? w_nx_m1 : w_xh[5:0];
    assign w_y1 = (w_yh > 7'(w_ny_m1)) ? w_ny_m1 : w_yh[5:0];

    // The window is complete once its far corner lies before the write position.
    assign w_in_vol = (r_oz < w_nz) && (7'(r_ox) < w_nx) && (7'(r_oy) < w_ny);
    assign w_ready  = w_in_vol &&
                      ((w_z1 < r_wz) ||
                       ((w_z1 == r_wz) && ((w_x1 < r_wx) ||
                                           ((w_x1 == r_wx) && (w_y1 < r_wy)))));
    assign w_fin    = (r_oz == w_nz_m1) && (r_ox == w_nx_m1) && (r_oy == w_ny_m1);

    // Offset from the output voxel back to the window's first voxel.
    logic [14:0]   w_off;
    logic [15:0]   w_start;
    logic [AW-1:0] w_start_a;

    assign w_off   = (r_dz[1] ? {1'b0, w_plane, 1'b0} : 15'd0)
                   + (r_dz[0] ? 15'(w_plane) : 15'd0)
                   + (r_dx[1] ? 15'({w_ny, 1'b0}) : 15'd0)
                   + (r_dx[0] ? 15'(w_ny) : 15'd0)
                   + 15'(r_dy);
    assign w_start = (16'(r_oaddr) >= 16'(w_off)) ? 16'(r_oaddr) - 16'(w_off)
                                                  : 16'(r_oaddr) + RING_D - 16'(w_off);
    assign w_start_a = AW'(w_start);

    assign o_item_pop = (r_state == ST_IDLE) && i_item_valid;
    assign w_mem_we   = o_item_pop && i_item.valid_req && (r_wz < w_nz);

    // Ring write at the write position and registered read of the walk address.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_waddr] <= i_item.voxel;
        end
        r_rdata <= r_mem[r_addr];
    end

    // Window bounds, start addresses and the sum; payload only.
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_acc <= r_acc + 23'(r_rdata);
        end
        case (r_state)
            ST_CHECK: begin
                r_z0 <= w_z0;
                r_z1 <= w_z1;
                r_x0 <= w_x0;
                r_x1 <= w_x1;
                r_y0 <= w_y0;
                r_y1 <= w_y1;
                r_dz <= 2'(r_oz - w_z0);
                r_dx <= 2'(r_ox - w_x0);
                r_dy <= 2'(r_oy - w_y0);
            end
            ST_SETUP: begin
                r_addr <= w_start_a;
                r_row  <= w_start_a;
                r_pln  <= w_start_a;
                r_cz   <= r_z0;
                r_cx   <= r_x0;
                r_cy   <= r_y0;
                r_acc  <= 23'd0;
            end
            ST_SUM: begin
                if (r_cy == r_y1) begin
                    r_cy <= r_y0;
                    if (r_cx == r_x1) begin
                        r_cx   <= r_x0;
                        r_cz   <= r_cz + 16'd1;
                        r_pln  <= wrap_add(r_pln, AW'(w_plane));
                        r_row  <= wrap_add(r_pln, AW'(w_plane));
                        r_addr <= wrap_add(r_pln, AW'(w_plane));
                    end else begin
                        r_cx   <= r_cx + 6'd1;
                        r_row  <= wrap_add(r_row, AW'(w_ny));
                        r_addr <= wrap_add(r_row, AW'(w_ny));
                    end
                end else begin
                    r_cy   <= r_cy + 6'd1;
                    r_addr <= wrap_add(r_addr, AW'(1));
                end
            end
            default: begin
            end
        endcase
        if ((r_state == ST_EMIT) && (!r_o_valid || i_ready)) begin
            r_o_sum  <= (r_acc > 23'd65535) ? 16'hFFFF : r_acc[15:0];
            r_o_last <= w_fin;
        end
    end

    // Sequencer, scan positions and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_y_size  <= 7'd64;
            r_x_size  <= 7'd64;
            r_z_size  <= 16'd64;
            r_half    <= 2'd1;
            r_wy      <= '0;
            r_wx      <= '0;
            r_wz      <= '0;
            r_oy      <= '0;
            r_ox      <= '0;
            r_oz      <= '0;
            r_waddr   <= '0;
            r_oaddr   <= '0;
        end else begin
            r_pend <= (r_state == ST_SUM);
            if (o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_Y_SIZE:     r_y_size <= i_cfg_data[6:0];
                    CFG_X_SIZE:     r_x_size <= i_cfg_data[6:0];
                    CFG_Z_SIZE:     r_z_size <= i_cfg_data;
                    CFG_HALF_WIDTH: r_half   <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
                r_wy    <= '0;
                r_wx    <= '0;
                r_wz    <= '0;
                r_oy    <= '0;
                r_ox    <= '0;
                r_oz    <= '0;
                r_waddr <= '0;
                r_oaddr <= '0;
            end else begin
                case (r_state)
                    ST_IDLE: begin
                        if (o_item_pop) begin
                            r_state <= ST_CHECK;
                        end
                        if (w_mem_we) begin
                            r_waddr <= wrap_add(r_waddr, AW'(1));
                            if (r_wy == w_ny_m1) begin
                                r_wy <= '0;
                                if (r_wx == w_nx_m1) begin
                                    r_wx <= '0;
                                    r_wz <= r_wz + 16'd1;
                                end else begin
                                    r_wx <= r_wx + 6'd1;
                                end
                            end else begin
                                r_wy <= r_wy + 6'd1;
                            end
                        end
                    end
                    ST_CHECK: begin
                        r_state <= w_ready ? ST_SETUP : ST_IDLE;
                    end
                    ST_SETUP: begin
                        r_state <= ST_SUM;
                    end
                    ST_SUM: begin
                        if ((r_cy == r_y1) && (r_cx == r_x1) && (r_cz == r_z1)) begin
                            r_state <= ST_LAST;
                        end
                    end
                    ST_LAST: begin
                        r_state <= ST_EMIT;
                    end
                    ST_EMIT: begin
                        if (!r_o_valid || i_ready) begin
                            r_o_valid <= 1'b1;
                            r_state   <= ST_IDLE;
                            if (w_fin) begin
                                r_wy    <= '0;
                                r_wx    <= '0;
                                r_wz    <= '0;
                                r_oy    <= '0;
                                r_ox    <= '0;
                                r_oz    <= '0;
                                r_waddr <= '0;
                                r_oaddr <= '0;
                            end else begin
                                r_oaddr <= wrap_add(r_oaddr, AW'(1));
                                if (r_oy == w_ny_m1) begin
                                    r_oy <= '0;
                                    if (r_ox == w_nx_m1) begin
                                        r_ox <= '0;
                                        r_oz <= r_oz + 16'd1;
                                    end else begin
                                        r_ox <= r_ox + 6'd1;
                                    end
                                end else begin
                                    r_oy <= r_oy + 6'd1;
                                end
                            end
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_valid    = r_o_valid;
    assign o_filtered = r_o_sum;
    assign o_last     = r_o_last;

endmodule

>>> rtl/core/volume_box_sum_filter.sv
// Clipped-window 3D box sum over a streamed volume of 16-bit voxels.
// Input channel (i_valid/o_ready): one beat per voxel in scan order, y fastest,
// then x, then z; i_valid_req low marks a drain beat that only advances output.
// Output channel (o_valid/i_ready): zero or one beat per input beat, carrying
// the saturated window sum and o_last on the final voxel of the volume.
// Configuration: i_cfg_we writes register i_cfg_idx (y, x, z size, half width)
// and restarts the scan; write only while the block is idle.
// Timing: a beat with no result due passes the idle and check states; one with
// a result also passes setup, sum, last and emit, and the window (up to 125
// voxels) is read one voxel per cycle from the read port of the plane ring,
// which sets the rate. The result is then held in the output register.
// A two-beat queue sits in front, so input is taken while the back end works.
// Reset is synchronous and active low; it restores the register defaults and
// scan positions. The ring needs no clearing: every entry is written before read.
// When the receiver stalls, the result waits in the output register and the
// back end holds once its next result is ready, while the queue keeps accepting until full.
module volume_box_sum_filter
    import vbsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_voxel,
    input  logic        i_valid_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_filtered,
    output logic        o_last
);

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_pop;

    // Accept and queue input beats.
    vbsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_voxel      (i_voxel),
        .i_valid_req  (i_valid_req),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    // Store voxels and sum the windows.
    vbsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_filtered   (o_filtered),
        .o_last       (o_last)
    );

endmodule
